/* hw/rtl/key_hash_shard_router_defines.svh */
// Assertion macros shared by the shard router RTL.
`ifndef KEY_HASH_SHARD_ROUTER_DEFINES_SVH
`define KEY_HASH_SHARD_ROUTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks a property on every rising edge of clk while arst_n is high.
`define KSHR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks that a condition never holds on a rising edge of clk.
`define KSHR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define KSHR_ASSERT(lbl, prop, msg)
`define KSHR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* hw/rtl/kshr_pkg.sv */
// Types, constants and codes shared by the shard router modules.
package kshr_pkg;

	localparam int MAX_SHARDS_DEF = 16;
	// The hash range is a power of two, so the reduction is a mask of the low bits.
	localparam int HASH_RANGE = 1024;
	localparam int HV_W = $clog2(HASH_RANGE);
	localparam int BOUND_W = 10;
	localparam int KEY_W = 8;
	localparam int ENTRY_W = 4;
	localparam int SHARD_W = 4;
	localparam int CFG_W = 5;
	localparam int HASH_W = 32;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	// Multiplying by 33 is a shift by five plus the value itself.
	localparam int HASH_SHIFT = 5;

	typedef enum logic [1:0] {
		CMD_KEY_BYTE    = 2'd0,
		CMD_EMPTY_KEY   = 2'd1,
		CMD_WRITE_ENTRY = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KEY_W-1:0]   key_byte;
		logic               last_byte;
		logic [ENTRY_W-1:0] entry_index;
		logic [BOUND_W-1:0] range_low;
		logic [BOUND_W-1:0] range_high;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [SHARD_W-1:0] shard_index;
		logic [HV_W-1:0]    hash_value;
	} out_item_t;

	typedef struct packed {
		logic               en;
		logic [ENTRY_W-1:0] addr;
		logic [BOUND_W-1:0] low;
		logic [BOUND_W-1:0] high;
	} tbl_wr_t;

	typedef struct packed {
		logic               done;
		logic               found;
		logic [SHARD_W-1:0] shard_index;
		logic [HV_W-1:0]    hash_value;
	} scan_res_t;

endpackage

/* hw/rtl/kshr_in_if.sv */
// Request channel interface: valid, ready and one command item.
interface kshr_in_if;
	logic               valid;
	logic               ready;
	kshr_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/kshr_out_if.sv */
// Result channel interface: valid, ready and one routing result item.
interface kshr_out_if;
	logic                valid;
	logic                ready;
	kshr_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/kshr_hash.sv */
// Hash accumulator: one key byte per step, hash = 33 * hash xor byte.
module kshr_hash (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic                                 clear,
	input  logic [kshr_pkg::KEY_W-1:0]           key_byte,
	output logic [kshr_pkg::HASH_W-1:0]          acc,
	output logic [kshr_pkg::HASH_W-1:0]          next_acc
);

	logic [kshr_pkg::HASH_W-1:0] acc_q;

	// The sum wraps at 32 bits, which is the modulo the hash wants.
	assign next_acc = ((acc_q << kshr_pkg::HASH_SHIFT) + acc_q) ^
		{{(kshr_pkg::HASH_W-kshr_pkg::KEY_W){1'b0}}, key_byte};
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= kshr_pkg::HASH_SEED;
		end else if (clear) begin
			acc_q <= kshr_pkg::HASH_SEED;
		end else if (step) begin
			acc_q <= next_acc;
		end
	end

endmodule

/* hw/rtl/kshr_scan.sv */
// Shard range table and the range scan that walks it one entry per cycle.
module kshr_scan #(
	parameter int MAX_SHARDS = kshr_pkg::MAX_SHARDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kshr_pkg::tbl_wr_t                 wr,
	input  logic                              start,
	input  logic [kshr_pkg::HV_W-1:0]         start_hv,
	input  logic [$clog2(MAX_SHARDS+1)-1:0]   start_count,
	output kshr_pkg::scan_res_t               res
);

	localparam int IDX_W = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
	localparam int CNT_W = $clog2(MAX_SHARDS + 1);

	logic [kshr_pkg::BOUND_W-1:0] low_mem [MAX_SHARDS];
	logic [kshr_pkg::BOUND_W-1:0] high_mem [MAX_SHARDS];

	logic                         busy_q;
	logic [CNT_W-1:0]             addr_q;
	logic [CNT_W-1:0]             count_q;
	logic [kshr_pkg::HV_W-1:0]    hv_q;
	logic                         rd_valid_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic [kshr_pkg::BOUND_W-1:0] rd_low_s1;
	logic [kshr_pkg::BOUND_W-1:0] rd_high_s1;
	logic                         done_q;
	logic                         found_q;
	logic [IDX_W-1:0]             found_idx_q;

	logic wr_ok;
	logic hit;
	logic issue;
	logic finish;

	assign wr_ok = wr.en && (32'(wr.addr) < MAX_SHARDS);

	// The one comparator pair, shared by every entry of the scan.
	assign hit = rd_valid_s1 && (hv_q >= rd_low_s1) && (hv_q <= rd_high_s1);
	assign issue = busy_q && !hit && (addr_q < count_q);
	assign finish = busy_q && (hit || (!rd_valid_s1 && (addr_q >= count_q)));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			low_mem[IDX_W'(wr.addr)] <= wr.low;
			high_mem[IDX_W'(wr.addr)] <= wr.high;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_low_s1 <= low_mem[addr_q[IDX_W-1:0]];
			rd_high_s1 <= high_mem[addr_q[IDX_W-1:0]];
			rd_idx_s1 <= addr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			addr_q <= '0;
			count_q <= '0;
			hv_q <= '0;
			rd_valid_s1 <= 1'b0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			found_idx_q <= '0;
		end else begin
			done_q <= finish;
			if (start) begin
				busy_q <= 1'b1;
				addr_q <= '0;
				count_q <= start_count;
				hv_q <= start_hv;
				rd_valid_s1 <= 1'b0;
			end else begin
				rd_valid_s1 <= issue;
				if (issue) begin
					addr_q <= CNT_W'(addr_q + 1'b1);
				end
				if (finish) begin
					busy_q <= 1'b0;
					found_q <= hit;
					found_idx_q <= hit ? rd_idx_s1 : '0;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.found = found_q;
	assign res.shard_index = kshr_pkg::SHARD_W'(found_idx_q);
	assign res.hash_value = hv_q;

endmodule

/* hw/rtl/key_hash_shard_router.sv */
// Top level of the key hash shard router: sequencer, config register, result register.
// Key bytes and table writes leave the sequencer idle, so the block stays ready for the next item.
// A lookup scans one entry per cycle through one shared comparator and stops at the first hit;
// the result goes to the output register, and the next item is taken from the loading edge on.
// arst_n clears the sequencer, shard_count to zero and the hash to 5381; the table is not cleared.
`include "key_hash_shard_router_defines.svh"

module key_hash_shard_router #(
	parameter int MAX_SHARDS = kshr_pkg::MAX_SHARDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	kshr_in_if.sink                      request,
	kshr_out_if.source                   result,
	input  logic                         shard_count_we,
	input  logic [kshr_pkg::CFG_W-1:0]   shard_count_wdata
);

	localparam int CNT_W = $clog2(MAX_SHARDS + 1);

	kshr_pkg::state_t state_q;
	kshr_pkg::state_t state_d;

	logic [kshr_pkg::CFG_W-1:0]  shard_count_q;
	logic [CNT_W-1:0]            scan_count;

	logic                        accept;
	logic                        is_key;
	logic                        is_empty;
	logic                        is_write;
	logic                        lookup;
	logic [kshr_pkg::HV_W-1:0]   start_hv;

	logic [kshr_pkg::HASH_W-1:0] acc;
	logic [kshr_pkg::HASH_W-1:0] next_acc;

	kshr_pkg::tbl_wr_t           tbl_wr;
	kshr_pkg::scan_res_t         scan_res;

	logic                        out_valid_q;
	kshr_pkg::out_item_t         out_data_q;
	logic                        out_free;
	logic                        load;

	// The block takes an item only while the sequencer is idle.
	assign request.ready = (state_q == kshr_pkg::ST_IDLE);
	assign accept = request.valid && request.ready;

	assign is_key = (request.data.cmd == kshr_pkg::CMD_KEY_BYTE);
	assign is_empty = (request.data.cmd == kshr_pkg::CMD_EMPTY_KEY);
	assign is_write = (request.data.cmd == kshr_pkg::CMD_WRITE_ENTRY);

	// A lookup starts on the last key byte or on an empty-key command. Both send the
	// hash back to its seed; the empty key also drops a partly streamed key.
	assign lookup = accept && ((is_key && request.data.last_byte) || is_empty);

	// The reduced hash is the low bits of the full hash, since the range is a power
	// of two. The last byte uses the updated hash from this same cycle.
	assign start_hv = is_empty ? kshr_pkg::HASH_SEED[kshr_pkg::HV_W-1:0]
	                           : next_acc[kshr_pkg::HV_W-1:0];

	// A count beyond the table depth searches the whole table.
	assign scan_count = (32'(shard_count_q) > MAX_SHARDS) ? CNT_W'(MAX_SHARDS)
	                                                       : CNT_W'(shard_count_q);

	assign tbl_wr.en = accept && is_write;
	assign tbl_wr.addr = request.data.entry_index;
	assign tbl_wr.low = request.data.range_low;
	assign tbl_wr.high = request.data.range_high;

	kshr_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept && is_key),
		.clear    (lookup),
		.key_byte (request.data.key_byte),
		.acc      (acc),
		.next_acc (next_acc)
	);

	kshr_scan #(
		.MAX_SHARDS (MAX_SHARDS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (tbl_wr),
		.start       (lookup),
		.start_hv    (start_hv),
		.start_count (scan_count),
		.res         (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shard_count_q <= '0;
		end else if (shard_count_we) begin
			shard_count_q <= shard_count_wdata;
		end
	end

	// The output register frees up in the cycle its item is taken, so a result
	// can follow the previous one without a gap.
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		load = 1'b0;
		case (state_q)
			kshr_pkg::ST_IDLE: begin
				if (lookup) begin
					state_d = kshr_pkg::ST_SCAN;
				end
			end
			kshr_pkg::ST_SCAN: begin
				if (scan_res.done) begin
					if (out_free) begin
						load = 1'b1;
						state_d = kshr_pkg::ST_IDLE;
					end else begin
						state_d = kshr_pkg::ST_HOLD;
					end
				end
			end
			kshr_pkg::ST_HOLD: begin
				// The scan keeps its result until the next start, so it is read here.
				if (out_free) begin
					load = 1'b1;
					state_d = kshr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kshr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kshr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.found <= scan_res.found;
			out_data_q.shard_index <= scan_res.shard_index;
			out_data_q.hash_value <= scan_res.hash_value;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_data_q;

	// A lookup moves the sequencer into the scan and sends the hash back to its seed.
	`KSHR_ASSERT(a_lookup_starts_scan, lookup |=> state_q == kshr_pkg::ST_SCAN, "lookup did not start a scan")
	`KSHR_ASSERT(a_lookup_reseeds, lookup |=> acc == kshr_pkg::HASH_SEED, "hash not reseeded after lookup")
	// The scan reports completion only while the sequencer waits for it.
	`KSHR_ASSERT(a_done_in_scan, scan_res.done |-> state_q == kshr_pkg::ST_SCAN, "scan done outside a scan")
	// A miss always reports shard zero.
	`KSHR_ASSERT_NEVER(a_miss_index_zero, result.valid && !result.data.found && (result.data.shard_index != '0), "miss with nonzero shard index")
	// A result is never loaded over one that is still waiting.
	`KSHR_ASSERT_NEVER(a_no_overwrite, load && out_valid_q && !result.ready, "result register overwritten")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the key hash shard router: directed and random items.
`timescale 1ns / 100ps

module testbench;
	import kshr_pkg::*;

	// Command code that the block has no use for; it must be dropped silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Marks a directed row that leaves shard_count as it is.
	localparam int NO_CFG = -1;
	// The empty key hashes to the seed, and 5381 mod 1024 is 261.
	localparam logic [HV_W-1:0] EMPTY_HV = 10'd261;
	// This margin covers the longest scan with room to spare.
	localparam int LOOKUP_TAIL = MAX_SHARDS_DEF + 8;
	localparam int CLK_HALF = 6;
	localparam int TIMEOUT_NS = 4_000_000;
	// The receiver stops taking results for this long once this many items went in.
	localparam int LONG_STALL_AT = 80;
	localparam int LONG_STALL_CYCLES = 400;
	localparam int END_WAIT_CYCLES = 4000;

	typedef struct {
		int               cfg_before;
		in_item_t         item;
		bit               typed;
		out_item_t        want;
	} table_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 shard_count_we;
	logic [CFG_W-1:0]     shard_count_wdata;

	kshr_in_if  req_ch ();
	kshr_out_if res_ch ();

	key_hash_shard_router i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.request           (req_ch),
		.result            (res_ch),
		.shard_count_we    (shard_count_we),
		.shard_count_wdata (shard_count_wdata)
	);

	// Our own copy of the router state, updated as each item is accepted.
	logic [HASH_W-1:0]    hash_model;
	logic [BOUND_W-1:0]   low_bound [MAX_SHARDS_DEF];
	logic [BOUND_W-1:0]   high_bound [MAX_SHARDS_DEF];
	logic [CFG_W-1:0]     shard_count_model;

	// Routing results still owed by the block, oldest first.
	out_item_t            expected_routes [$];
	table_row_t           directed_rows [$];

	int                   mismatches;
	int                   accepted_items;
	int                   send_idle_pct;
	int                   recv_idle_pct;

	always #(CLK_HALF) clk = ~clk;

	// Search the in-use part of the shard table for the first range that holds the
	// reduced hash. A count above the table size searches the whole table.
	function automatic out_item_t shard_lookup(input logic [HASH_W-1:0] full_hash);
		out_item_t        res;
		int               limit;
		logic [HV_W-1:0]  hv;
		hv = HV_W'(full_hash % HASH_RANGE);
		limit = (shard_count_model > MAX_SHARDS_DEF) ? MAX_SHARDS_DEF : shard_count_model;
		res = '0;
		res.hash_value = hv;
		for (int e = 0; e < limit; e++) begin
			if (hv >= low_bound[e] && hv <= high_bound[e]) begin
				res.found = 1'b1;
				res.shard_index = SHARD_W'(e);
				break;
			end
		end
		return res;
	endfunction

	// Apply one accepted item to the state copy. Returns 1 when the item is a lookup,
	// with the routing result the block owes for it.
	function automatic bit route_item(input in_item_t it, output out_item_t res);
		res = '0;
		case (it.cmd)
			CMD_KEY_BYTE: begin
				// DJB2 with xor: multiply by 33 modulo 2^32, then fold in the byte.
				hash_model = (hash_model * 32'd33) ^ {24'd0, it.key_byte};
				if (it.last_byte) begin
					res = shard_lookup(hash_model);
					hash_model = HASH_SEED;
					return 1'b1;
				end
			end
			CMD_EMPTY_KEY: begin
				// Any partly streamed key is thrown away.
				res = shard_lookup(HASH_SEED);
				hash_model = HASH_SEED;
				return 1'b1;
			end
			CMD_WRITE_ENTRY: begin
				low_bound[it.entry_index] = it.range_low;
				high_bound[it.entry_index] = it.range_high;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	function automatic table_row_t mk_row(input int cfg, input logic [1:0] cmd,
			input logic [KEY_W-1:0] kb, input logic lb, input logic [ENTRY_W-1:0] ei,
			input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi,
			input bit typed = 1'b0, input logic [HV_W-1:0] hv = '0,
			input logic fnd = 1'b0, input logic [SHARD_W-1:0] sh = '0);
		table_row_t row;
		row.cfg_before = cfg;
		row.item.cmd = cmd;
		row.item.key_byte = kb;
		row.item.last_byte = lb;
		row.item.entry_index = ei;
		row.item.range_low = lo;
		row.item.range_high = hi;
		row.typed = typed;
		row.want.found = fnd;
		row.want.shard_index = sh;
		row.want.hash_value = hv;
		return row;
	endfunction

	// Every field gets random bits; callers then fix the ones that matter.
	function automatic in_item_t rand_item();
		in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.key_byte = 8'($urandom_range(0, 255));
		it.last_byte = 1'($urandom_range(0, 1));
		it.entry_index = 4'($urandom_range(0, 15));
		it.range_low = 10'($urandom_range(0, 1023));
		it.range_high = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	// Offer one item, idling first at the current sender rate. On return the item has
	// been taken and valid is still high, so a following item can go out back to back when no idling is drawn.
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_want);
		out_item_t  predicted;
		bit         is_lookup;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
		is_lookup = route_item(it, predicted);
		if (is_lookup) begin
			expected_routes.push_back(typed ? typed_want : predicted);
		end
		accepted_items++;
	endtask

	// Stop offering and wait for every owed result to come out.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_routes.size() != 0) @(posedge clk);
	endtask

	// The count register may only change while the block is idle. Key bytes and table
	// writes give no result, but every lookup owes one until it comes out, so no scan runs
	// once the queue empties; the tail wait adds margin on top.
	task automatic write_shard_count(input logic [CFG_W-1:0] value);
		wait_drained();
		repeat (LOOKUP_TAIL) @(posedge clk);
		shard_count_we <= 1'b1;
		shard_count_wdata <= value;
		@(posedge clk);
		shard_count_we <= 1'b0;
		shard_count_model = value;
	endtask

	// One random phase: a count setting, an idling mix, then mostly well-formed keys.
	task automatic run_phase(input int n_items, input logic [CFG_W-1:0] cfg,
			input int s_idle, input int r_idle);
		int         sent;
		int         pick;
		int         len;
		int         span;
		in_item_t   it;
		out_item_t  none;
		sent = 0;
		none = '0;
		write_shard_count(cfg);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// A key of one to eight bytes. Now and then it is cut short by an
				// empty-key lookup, or has a dropped command slipped in between bytes.
				len = $urandom_range(1, 8);
				for (int b = 0; b < len; b++) begin
					it = rand_item();
					it.cmd = CMD_KEY_BYTE;
					it.last_byte = (b == len - 1);
					if (!it.last_byte && $urandom_range(0, 15) == 0) begin
						it.cmd = CMD_EMPTY_KEY;
						send_item(it, 1'b0, none);
						sent++;
						break;
					end
					send_item(it, 1'b0, none);
					sent++;
					if (!it.last_byte && $urandom_range(0, 19) == 0) begin
						it = rand_item();
						it.cmd = CMD_UNUSED;
						send_item(it, 1'b0, none);
					end
				end
			end else if (pick < 72) begin
				it = rand_item();
				it.cmd = CMD_EMPTY_KEY;
				send_item(it, 1'b0, none);
				sent++;
			end else if (pick < 90) begin
				// Table write. Half the ranges are short and well formed so that lookups hit
				// now and then; the rest are fully random or deliberately inverted.
				it = rand_item();
				it.cmd = CMD_WRITE_ENTRY;
				case ($urandom_range(0, 3))
					0, 1: begin
						span = it.range_low + $urandom_range(0, 255);
						it.range_high = (span > 1023) ? 10'd1023 : 10'(span);
					end
					3: begin
						if (it.range_low != 0) begin
							it.range_high = it.range_low - 10'($urandom_range(1, it.range_low));
						end
					end
					default: begin
					end
				endcase
				send_item(it, 1'b0, none);
				sent++;
			end else if (pick < 97) begin
				// Dropped commands do not count toward the phase size.
				it = rand_item();
				it.cmd = CMD_UNUSED;
				send_item(it, 1'b0, none);
			end else begin
				// The sender goes quiet until the block has delivered everything.
				wait_drained();
			end
		end
	endtask

	// Result side: random back-pressure, plus one long hold-off while the sender keeps
	// offering, so that a result sits in the output register and the input stalls.
	initial begin
		int stall_left;
		bit stall_done;
		stall_left = 0;
		stall_done = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!stall_done && accepted_items >= LONG_STALL_AT) begin
				stall_done = 1'b1;
				stall_left = LONG_STALL_CYCLES;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Every result taken is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_routes.size() == 0) begin
				$error("routing result %h arrived with nothing outstanding", res_ch.data);
				mismatches++;
			end else begin
				want = expected_routes.pop_front();
				if (res_ch.data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, res_ch.data.found);
					mismatches++;
				end
				if (res_ch.data.shard_index !== want.shard_index) begin
					$error("shard_index: expected %0d, got %0d",
						want.shard_index, res_ch.data.shard_index);
					mismatches++;
				end
				if (res_ch.data.hash_value !== want.hash_value) begin
					$error("hash_value: expected %0d, got %0d",
						want.hash_value, res_ch.data.hash_value);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, directed rows, six random phases, then the final verdict.
	initial begin
		int wait_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		shard_count_we = 1'b0;
		shard_count_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		hash_model = HASH_SEED;
		shard_count_model = '0;
		mismatches = 0;
		accepted_items = 0;
		// The directed part runs with the sender idling lightly and the receiver a lot.
		send_idle_pct = 32;
		recv_idle_pct = 76;

		// Right after reset no entry is in use, so the empty key finds nothing.
		directed_rows.push_back(mk_row(NO_CFG, CMD_EMPTY_KEY, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0,
			1'b1, EMPTY_HV, 1'b0, 4'd0));
		// A zero byte is hashed like any other; the key ends on the largest byte.
		directed_rows.push_back(mk_row(NO_CFG, CMD_KEY_BYTE, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0));
		directed_rows.push_back(mk_row(NO_CFG, CMD_KEY_BYTE, 8'hFF, 1'b1, 4'h0, 10'd0, 10'd0));
		// The unused command with every other field at its maximum is dropped.
		directed_rows.push_back(mk_row(NO_CFG, CMD_UNUSED, 8'hFF, 1'b1, 4'hF,
			10'd1023, 10'd1023));
		// Entry zero is inverted and can never match; entry one holds just the empty-key hash.
		directed_rows.push_back(mk_row(NO_CFG, CMD_WRITE_ENTRY, 8'h00, 1'b0, 4'd0,
			10'd1023, 10'd0));
		directed_rows.push_back(mk_row(NO_CFG, CMD_WRITE_ENTRY, 8'h00, 1'b0, 4'd1,
			EMPTY_HV, EMPTY_HV));
		directed_rows.push_back(mk_row(NO_CFG, CMD_WRITE_ENTRY, 8'h00, 1'b0, 4'd2,
			10'd0, 10'd1023));
		directed_rows.push_back(mk_row(NO_CFG, CMD_WRITE_ENTRY, 8'h00, 1'b0, 4'd3,
			10'd1023, 10'd1023));
		// The rest of the table gets disjoint blocks of 64 so that every entry is written.
		for (int e = 4; e < MAX_SHARDS_DEF; e++) begin
			directed_rows.push_back(mk_row(NO_CFG, CMD_WRITE_ENTRY, 8'h00, 1'b0, ENTRY_W'(e),
				BOUND_W'(e * 64), BOUND_W'(e * 64 + 63)));
		end
		// Only the inverted entry in use: still nothing found.
		directed_rows.push_back(mk_row(1, CMD_EMPTY_KEY, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0,
			1'b1, EMPTY_HV, 1'b0, 4'd0));
		// Two entries in use: the search skips the inverted one and lands on entry one.
		directed_rows.push_back(mk_row(2, CMD_EMPTY_KEY, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0,
			1'b1, EMPTY_HV, 1'b1, 4'd1));
		// A partly streamed key is discarded by an empty-key lookup.
		directed_rows.push_back(mk_row(NO_CFG, CMD_KEY_BYTE, 8'h61, 1'b0, 4'h0, 10'd0, 10'd0));
		directed_rows.push_back(mk_row(NO_CFG, CMD_EMPTY_KEY, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0,
			1'b1, EMPTY_HV, 1'b1, 4'd1));
		// A count beyond the table size searches the full table.
		directed_rows.push_back(mk_row(31, CMD_KEY_BYTE, 8'h55, 1'b1, 4'h0, 10'd0, 10'd0));
		directed_rows.push_back(mk_row(16, CMD_EMPTY_KEY, 8'h00, 1'b0, 4'h0, 10'd0, 10'd0,
			1'b1, EMPTY_HV, 1'b1, 4'd1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].cfg_before != NO_CFG) begin
				write_shard_count(CFG_W'(directed_rows[r].cfg_before));
			end
			send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
		end

		// Idling goes sender-light/receiver-heavy, then the reverse, then none at all,
		// while the count walks through both extremes and a few values in between.
		run_phase(140, 5'd16, 32, 76);
		run_phase(140, 5'd0, 32, 76);
		run_phase(140, 5'd31, 76, 32);
		run_phase(140, 5'd5, 76, 32);
		run_phase(140, CFG_W'($urandom_range(0, 31)), 0, 0);
		run_phase(140, 5'd1, 0, 0);

		// Let the last results drain, bounded, and then a little longer for stray output.
		req_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (expected_routes.size() != 0 && wait_cycles < END_WAIT_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LOOKUP_TAIL) @(posedge clk);
		if (expected_routes.size() != 0) begin
			$error("%0d routing results never arrived", expected_routes.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
